// ===== sv/ubs_pkg.sv =====
`timescale 1ns / 1ps
package ubs_pkg;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_READ      = 4'd1,
    PH_WRITE     = 4'd2,
    PH_ACK       = 4'd3,
    PH_ACKSTALL  = 4'd4,
    PH_COMPLETED = 4'd5,
    PH_FAILURE   = 4'd6,
    PH_ERROR     = 4'd7,
    PH_SUSPEND   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_ARM       = 3'd1,
    ACT_RESP_CSW  = 3'd2,
    ACT_RESP_ONLY = 3'd3,
    ACT_READ      = 3'd4,
    ACT_WRITE     = 3'd5,
    ACT_CSW       = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    RK_NONE     = 3'd0,
    RK_SENSE    = 3'd1,
    RK_INQUIRY  = 3'd2,
    RK_MODE6    = 3'd3,
    RK_MODE10   = 3'd4,
    RK_FMTCAP   = 3'd5,
    RK_CAPACITY = 3'd6
  } resp_e;

  typedef enum logic [1:0] {
    CSW_PASSED = 2'd0,
    CSW_FAILED = 2'd1,
    CSW_PHASE  = 2'd2
  } csw_e;

  localparam logic [1:0] MODE_CBW   = 2'd0;
  localparam logic [1:0] MODE_DONE  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [1:0] CMPL_OK   = 2'd0;
  localparam logic [1:0] CMPL_HARD = 2'd1;

  localparam logic [31:0] CBW_SIG = 32'h43425355;
  localparam int unsigned DIR_IN_BIT = 7;
  localparam logic [4:0] CDB_MAX = 5'd16;

  localparam logic [7:0] OP_TUR      = 8'h00;
  localparam logic [7:0] OP_SENSE    = 8'h03;
  localparam logic [7:0] OP_INQUIRY  = 8'h12;
  localparam logic [7:0] OP_MODE6    = 8'h1A;
  localparam logic [7:0] OP_MODE10   = 8'h5A;
  localparam logic [7:0] OP_FMTCAP   = 8'h23;
  localparam logic [7:0] OP_CAPACITY = 8'h25;
  localparam logic [7:0] OP_READ6    = 8'h08;
  localparam logic [7:0] OP_READ10   = 8'h28;
  localparam logic [7:0] OP_READ12   = 8'hA8;
  localparam logic [7:0] OP_WRITE6   = 8'h0A;
  localparam logic [7:0] OP_WRITE10  = 8'h2A;
  localparam logic [7:0] OP_WRITE12  = 8'hAA;
  localparam logic [7:0] OP_VERIFY   = 8'h2F;

  localparam logic [5:0] LEN_SENSE    = 6'd18;
  localparam logic [5:0] LEN_INQUIRY  = 6'd36;
  localparam logic [5:0] LEN_MODE6    = 6'd4;
  localparam logic [5:0] LEN_MODE10   = 6'd8;
  localparam logic [5:0] LEN_FMTCAP   = 6'd12;
  localparam logic [5:0] LEN_CAPACITY = 6'd8;

  localparam logic [8:0] CNT6_ZERO = 9'd256;

  localparam logic [16:0] BLOCK_LENGTH_RESET = 17'd512;
  localparam logic REG_BLOCK_COUNT  = 1'b0;
  localparam logic REG_BLOCK_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] signature;
    logic [31:0] cbw_tag;
    logic [31:0] host_length;
    logic [7:0]  cbw_flags;
    logic [3:0]  unit_number;
    logic [4:0]  cdb_length;
    logic [63:0] cdb_low;
    logic [63:0] cdb_high;
    logic [1:0]  completion;
  } in_t;

  typedef struct packed {
    action_e     action;
    resp_e       response_kind;
    logic [31:0] status_tag;
    logic [31:0] residue;
    csw_e        csw_status;
    logic [47:0] byte_position;
    logic [5:0]  response_bytes;
    logic        stall_in;
    logic        stall_out;
    phase_e      phase;
  } out_t;

endpackage

// ===== sv/usb_bulk_only_scsi_command_fsm.sv =====
`timescale 1ns / 1ps
// channel   handshake                   payload
// in        in_valid_i / in_ready_o     in_data_i  (in_t)
// out       out_valid_o / out_ready_i   out_data_o (out_t)
// config    psel penable pwrite pready  paddr pwdata prdata
//
// an event is registered in the input register on accept and handled from there; its
// result (if any) is loaded into the output register when the event is handled
// one event per cycle sustained while the output is not stalled; the phase update is the single loop
// a stalled output holds the handling stage, which holds the input register
// reset: phase suspend, saved fields zero, block_length 512, block_count 0
module usb_bulk_only_scsi_command_fsm
  import ubs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] block_count_q;
  logic [16:0] block_length_q;

  in_t         in_q;
  logic        in_valid_q;
  out_t        out_q, res;
  logic        out_valid_q, emit;
  logic        advance;

  phase_e      phase_q, phase_d;
  logic [31:0] tag_q, tag_d, len_q, len_d, left_q, left_d;
  logic [7:0]  flags_q, flags_d, opcode_q, opcode_d;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_LENGTH) ? {15'd0, block_length_q} : block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q  <= '0;
      block_length_q <= BLOCK_LENGTH_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BLOCK_LENGTH) block_length_q <= pwdata[16:0];
      else block_count_q <= pwdata;
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // command block fields
  logic [7:0]  op, b1, b2, b3, b4, b5, b6, b7, b8, b9;
  logic [31:0] lba, cnt;
  logic [48:0] total, pos_full;
  logic [32:0] range_end;
  logic        rw_ok;

  always_comb begin
    op = in_q.cdb_low[63:56];
    b1 = in_q.cdb_low[55:48];
    b2 = in_q.cdb_low[47:40];
    b3 = in_q.cdb_low[39:32];
    b4 = in_q.cdb_low[31:24];
    b5 = in_q.cdb_low[23:16];
    b6 = in_q.cdb_low[15:8];
    b7 = in_q.cdb_low[7:0];
    b8 = in_q.cdb_high[63:56];
    b9 = in_q.cdb_high[55:48];
    if (op == OP_READ6 || op == OP_WRITE6) begin
      lba = {11'd0, b1[4:0], b2, b3};
      cnt = (b4 == 8'd0) ? {23'd0, CNT6_ZERO} : {24'd0, b4};
    end else if (op == OP_READ10 || op == OP_WRITE10) begin
      lba = {b2, b3, b4, b5};
      cnt = {16'd0, b7, b8};
    end else begin
      lba = {b2, b3, b4, b5};
      cnt = {b6, b7, b8, b9};
    end
    total     = cnt * block_length_q;
    pos_full  = lba * block_length_q;
    range_end = {1'b0, lba} + {1'b0, cnt};
    rw_ok = (total != '0) && (total == {17'd0, in_q.host_length})
            && (range_end <= {1'b0, block_count_q});
  end

  function automatic out_t csw_f(logic [31:0] tag, logic [31:0] residue, csw_e st,
                                 phase_e ph);
    out_t r;
    r = '0;
    r.action     = ACT_CSW;
    r.status_tag = tag;
    r.residue    = residue;
    r.csw_status = st;
    r.phase      = ph;
    return r;
  endfunction

  function automatic out_t arm_f(logic sin, logic sout);
    out_t r;
    r = '0;
    r.action    = ACT_ARM;
    r.stall_in  = sin;
    r.stall_out = sout;
    r.phase     = PH_IDLE;
    return r;
  endfunction

  function automatic out_t suspend_f();
    out_t r;
    r = '0;
    r.stall_in  = 1'b1;
    r.stall_out = 1'b1;
    r.phase     = PH_SUSPEND;
    return r;
  endfunction

  logic        is_resp;
  resp_e       rkind;
  logic [5:0]  rlen;

  always_comb begin
    is_resp = 1'b1;
    rkind   = RK_NONE;
    rlen    = '0;
    case (op)
      OP_SENSE:    begin rkind = RK_SENSE;    rlen = LEN_SENSE;    end
      OP_INQUIRY:  begin rkind = RK_INQUIRY;  rlen = LEN_INQUIRY;  end
      OP_MODE6:    begin rkind = RK_MODE6;    rlen = LEN_MODE6;    end
      OP_MODE10:   begin rkind = RK_MODE10;   rlen = LEN_MODE10;   end
      OP_FMTCAP:   begin rkind = RK_FMTCAP;   rlen = LEN_FMTCAP;   end
      OP_CAPACITY: begin rkind = RK_CAPACITY; rlen = LEN_CAPACITY; end
      default:     is_resp = 1'b0;
    endcase
  end

  always_comb begin
    res      = '0;
    emit     = 1'b0;
    tag_d    = tag_q;
    len_d    = len_q;
    flags_d  = flags_q;
    opcode_d = opcode_q;
    left_d   = left_q;
    case (in_q.mode)
      MODE_CBW: begin
        if (phase_q == PH_IDLE) begin
          emit      = 1'b1;
          res.phase = PH_IDLE;
          if (in_q.signature == CBW_SIG) begin
            tag_d    = in_q.cbw_tag;
            len_d    = in_q.host_length;
            flags_d  = in_q.cbw_flags;
            opcode_d = op;
            left_d   = in_q.host_length;
            if (in_q.unit_number != 4'd0 || in_q.cdb_length == 5'd0
                || in_q.cdb_length > CDB_MAX) begin
              res = csw_f(in_q.cbw_tag, in_q.host_length, CSW_PHASE, PH_ERROR);
            end else if (is_resp) begin
              if (in_q.host_length == '0 || !in_q.cbw_flags[DIR_IN_BIT]) begin
                res = csw_f(in_q.cbw_tag, in_q.host_length, CSW_PHASE, PH_ERROR);
              end else if (in_q.host_length >= {26'd0, rlen}) begin
                left_d             = in_q.host_length - {26'd0, rlen};
                res.action         = ACT_RESP_CSW;
                res.response_kind  = rkind;
                res.status_tag     = in_q.cbw_tag;
                res.response_bytes = rlen;
                res.phase          = PH_COMPLETED;
              end else begin
                // response longer than the host asked for: stall in later
                left_d             = '0;
                res.action         = ACT_RESP_ONLY;
                res.response_kind  = rkind;
                res.response_bytes = rlen;
                res.phase          = PH_ACKSTALL;
              end
            end else begin
              case (op)
                OP_TUR: begin
                  if (in_q.host_length == '0)
                    res = csw_f(in_q.cbw_tag, '0, CSW_PASSED, PH_ACK);
                  else
                    res = csw_f(in_q.cbw_tag, in_q.host_length, CSW_PHASE, PH_ERROR);
                end
                OP_READ6, OP_READ10, OP_READ12,
                OP_WRITE6, OP_WRITE10, OP_WRITE12: begin
                  if (rw_ok) begin
                    res.residue       = in_q.host_length;
                    res.byte_position = pos_full[47:0];
                    if (op == OP_READ6 || op == OP_READ10 || op == OP_READ12) begin
                      res.action = ACT_READ;
                      res.phase  = PH_READ;
                    end else begin
                      res.action = ACT_WRITE;
                      res.phase  = PH_WRITE;
                    end
                  end else begin
                    res = csw_f(in_q.cbw_tag, in_q.host_length, CSW_FAILED, PH_FAILURE);
                  end
                end
                OP_VERIFY: res = arm_f(1'b0, 1'b0);
                default:
                  res = csw_f(in_q.cbw_tag, in_q.host_length, CSW_FAILED, PH_FAILURE);
              endcase
            end
          end
        end
      end
      MODE_DONE: begin
        emit = 1'b1;
        case (phase_q)
          PH_READ, PH_WRITE: begin
            if (in_q.completion == CMPL_OK) res = csw_f(tag_q, '0, CSW_PASSED, PH_ACK);
            else if (in_q.completion == CMPL_HARD) res = suspend_f();
            else res = csw_f(tag_q, left_q, CSW_FAILED, PH_FAILURE);
          end
          PH_ACK, PH_COMPLETED: begin
            if (in_q.completion == CMPL_OK) res = arm_f(1'b0, 1'b0);
            else res = suspend_f();
          end
          PH_ACKSTALL: begin
            if (in_q.completion == CMPL_OK) begin
              res = csw_f(tag_q, left_q, CSW_PASSED, PH_COMPLETED);
              res.stall_in = 1'b1;
            end else begin
              res = suspend_f();
            end
          end
          PH_FAILURE: begin
            if (in_q.completion != CMPL_OK) res = suspend_f();
            else if (len_q == '0) res = arm_f(1'b0, 1'b0);
            else if (flags_q[DIR_IN_BIT]) res = arm_f(1'b1, 1'b0);
            else res = arm_f(1'b0, 1'b1);
          end
          PH_ERROR: res = suspend_f();
          default: emit = 1'b0;
        endcase
      end
      MODE_RESET: begin
        emit = 1'b1;
        res  = arm_f(1'b0, 1'b0);
      end
      default: emit = 1'b0;
    endcase
    phase_d = emit ? res.phase : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_SUSPEND;
      tag_q       <= '0;
      len_q       <= '0;
      flags_q     <= '0;
      opcode_q    <= '0;
      left_q      <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= emit;
        phase_q     <= phase_d;
        tag_q       <= tag_d;
        len_q       <= len_d;
        flags_q     <= flags_d;
        opcode_q    <= opcode_d;
        left_q      <= left_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance && emit) out_q <= res;
  end

`ifndef SYNTHESIS
  a_phase_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (phase_q == out_q.phase))
    else $error("phase register differs from the delivered phase");
  a_read_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == ACT_READ) |-> (out_q.phase == PH_READ))
    else $error("read request without read phase");
  a_arm_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == ACT_ARM) |-> (out_q.phase == PH_IDLE))
    else $error("receive armed outside idle");
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_valid_q) |-> !in_ready_o)
    else $error("input taken while output stage is blocked");
`endif

endmodule
